// ----- hw/rtl/impulse_time_bin_accumulator_macros.svh -----
// ----------------------------------------------------------------------------
// Impulse time-bin accumulator assertion macros
// Shared shorthand for the concurrent checks of the accumulator.
// ----------------------------------------------------------------------------
`ifndef IMPULSE_TIME_BIN_ACCUMULATOR_MACROS_SVH
`define IMPULSE_TIME_BIN_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define ITBA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("accumulator check failed");

// Next-cycle implication, held off while reset is high.
`define ITBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("accumulator check failed");

`endif

// ----- hw/rtl/itba_pkg.sv -----
// ----------------------------------------------------------------------------
// Impulse time-bin accumulator package
// Command codes, register indexes, field widths and the saturating add.
// ----------------------------------------------------------------------------
package itba_pkg;

   // Field widths.
   localparam int unsigned CMD_W       = 2;
   localparam int unsigned TIME_W      = 32;
   localparam int unsigned VOL_W       = 24;
   localparam int unsigned SUM_W       = 32;
   localparam int unsigned RATE_W      = 18;
   localparam int unsigned LIMIT_W     = 16;
   localparam int unsigned LEN_W       = 17;
   localparam int unsigned PROD_W      = 50;
   localparam int unsigned ROUND_SHIFT = 20;
   localparam int unsigned BIN_W       = PROD_W - ROUND_SHIFT;
   localparam int unsigned MAX_BANDS   = 8;
   localparam int unsigned CSR_IDX_W   = 1;
   localparam int unsigned CSR_DATA_W  = 18;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BIN     = 1'd1;

   // Register reset values.
   localparam logic [RATE_W-1:0]  RATE_RESET    = 18'd44100;
   localparam logic [LIMIT_W-1:0] MAX_BIN_RESET = 16'hFFFF;

   // Half a bin in the product's scale, for round half up.
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [VOL_W-1:0] vol_type;

   // Adds a volume into a band sum, clamping at the 32-bit signed limits.
   function automatic sum_type sat_add(input sum_type acc, input vol_type vol);
      logic signed [SUM_W:0] total;
      begin
         total = {acc[SUM_W-1], acc} + {{(SUM_W + 1 - VOL_W){vol[VOL_W-1]}}, vol};
         if (total[SUM_W] != total[SUM_W-1]) begin
            sat_add = total[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                   : {1'b0, {(SUM_W - 1){1'b1}}};
         end else begin
            sat_add = total[SUM_W-1:0];
         end
      end
   endfunction

endpackage

// ----- hw/rtl/impulse_time_bin_accumulator.sv -----
// ----------------------------------------------------------------------------
// Impulse time-bin accumulator
// Scatters impulses into per-band sample bins held in one wide memory.
// ----------------------------------------------------------------------------
// Usage:
//   A command transfers in at a clock edge with start high and busy low.
//   Add (req_cmd 0) maps req_arrival_time to a bin, rounded half up, and
//   adds the band volumes with saturation unless the bin is past max_bin or
//   the last entry. Read (req_cmd 1) returns the bin's sums, the response
//   length and the bin index, then clears the bin. Restart (req_cmd 2)
//   zeroes the length tracker. Only a read produces a result: rsp_valid is
//   high for one cycle, after the bin and write-back states, and the receiver
//   cannot stall it. Every command has a bin step, which forms the bin and
//   reads the memory port, then a write-back step, which modifies and writes
//   back. busy drops during write-back, so a new command can overlap it. After
//   reset a clearing pass writes zero to all BIN_DEPTH entries, one per cycle,
//   with busy high throughout. Register writes on the csr_ port are taken at
//   any time and are meant for idle periods.
// ----------------------------------------------------------------------------
`include "impulse_time_bin_accumulator_macros.svh"

module impulse_time_bin_accumulator
   import itba_pkg::*;
#(
   parameter int unsigned BIN_DEPTH = 65536,
   parameter int unsigned BANDS     = 8
)(
   input  logic                    clock,
   input  logic                    reset,
   // Command channel
   input  logic                    start,
   output logic                    busy,
   input  logic [CMD_W-1:0]        req_cmd,
   input  logic [TIME_W-1:0]       req_arrival_time,
   input  logic signed [VOL_W-1:0] req_band_volume_0,
   input  logic signed [VOL_W-1:0] req_band_volume_1,
   input  logic signed [VOL_W-1:0] req_band_volume_2,
   input  logic signed [VOL_W-1:0] req_band_volume_3,
   input  logic signed [VOL_W-1:0] req_band_volume_4,
   input  logic signed [VOL_W-1:0] req_band_volume_5,
   input  logic signed [VOL_W-1:0] req_band_volume_6,
   input  logic signed [VOL_W-1:0] req_band_volume_7,
   input  logic [LIMIT_W-1:0]      req_read_index,
   // Result channel
   output logic                    rsp_valid,
   output logic signed [SUM_W-1:0] rsp_band_sum_0,
   output logic signed [SUM_W-1:0] rsp_band_sum_1,
   output logic signed [SUM_W-1:0] rsp_band_sum_2,
   output logic signed [SUM_W-1:0] rsp_band_sum_3,
   output logic signed [SUM_W-1:0] rsp_band_sum_4,
   output logic signed [SUM_W-1:0] rsp_band_sum_5,
   output logic signed [SUM_W-1:0] rsp_band_sum_6,
   output logic signed [SUM_W-1:0] rsp_band_sum_7,
   output logic [LEN_W-1:0]        rsp_response_length,
   output logic [LIMIT_W-1:0]      rsp_bin_echo,
   // Register write port
   input  logic                    csr_write_en,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int unsigned ADDR_W  = $clog2(BIN_DEPTH);
   localparam int unsigned WORD_W  = BANDS * SUM_W;
   localparam int unsigned WIDE_W  = MAX_BANDS * SUM_W;
   localparam int unsigned IDX_W   = ((ADDR_W > LIMIT_W) ? ADDR_W : LIMIT_W) + 1;
   localparam int unsigned CAP_INT = (BIN_DEPTH - 1 > 65535) ? 65535 : BIN_DEPTH - 1;
   localparam logic [LIMIT_W-1:0] CAP_LIMIT = LIMIT_W'(CAP_INT);
   localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(BIN_DEPTH - 1);

   // Sequencer states.
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_BIN   = 2'd2;
   localparam logic [1:0] ST_MOD   = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [ADDR_W-1:0]    clr_addr_ff;
   logic [RATE_W-1:0]    sample_rate_ff;
   logic [LIMIT_W-1:0]   max_bin_ff;
   logic [LIMIT_W-1:0]   largest_ff, largest_in;

   logic [CMD_W-1:0]     cmd_ff;
   logic [PROD_W-1:0]    prod_ff;
   vol_type              vol_ff [MAX_BANDS];
   vol_type              vol_req [MAX_BANDS];
   logic [LIMIT_W-1:0]   read_index_ff;

   logic [ADDR_W-1:0]    addr_ff, rd_addr;
   logic                 wr_en_ff, wr_en_in;
   logic                 in_range_ff;
   logic [WORD_W-1:0]    rd_data_ff;

   logic                 rsp_valid_ff;
   sum_type              rsp_sum_ff [MAX_BANDS];
   logic [LIMIT_W-1:0]   rsp_bin_echo_ff;
   logic [LEN_W-1:0]     rsp_len_ff;

   logic                 accept;
   logic [PROD_W-1:0]    prod_round;
   logic [BIN_W-1:0]     bin_val;
   logic [LIMIT_W-1:0]   cap;
   logic                 in_cap;
   logic [LIMIT_W-1:0]   clipped;
   logic [IDX_W-1:0]     idx_ext;
   logic                 idx_in_range;

   logic [WIDE_W-1:0]    rd_wide, add_wide;
   logic                 mem_we;
   logic [ADDR_W-1:0]    mem_waddr;
   logic [WORD_W-1:0]    mem_wdata;
   logic [WORD_W-1:0]    bin_mem [BIN_DEPTH];

   assign busy   = (state_ff == ST_CLEAR) || (state_ff == ST_BIN);
   assign accept = start && !busy;

   assign vol_req[0] = req_band_volume_0;
   assign vol_req[1] = req_band_volume_1;
   assign vol_req[2] = req_band_volume_2;
   assign vol_req[3] = req_band_volume_3;
   assign vol_req[4] = req_band_volume_4;
   assign vol_req[5] = req_band_volume_5;
   assign vol_req[6] = req_band_volume_6;
   assign vol_req[7] = req_band_volume_7;

   // Sequencer: clearing pass after reset, then bin/read and write-back cycles.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_BIN;
            end
         end
         ST_BIN: begin
            state_in = ST_MOD;
         end
         ST_MOD: begin
            state_in = accept ? ST_BIN : ST_IDLE;
         end
      endcase
   end

   // Bin index from the registered product, and the clipping limit.
   always_comb begin
      prod_round = prod_ff + ROUND_HALF;
      bin_val    = prod_round[PROD_W-1:ROUND_SHIFT];
      cap        = (max_bin_ff > CAP_LIMIT) ? CAP_LIMIT : max_bin_ff;
      in_cap     = bin_val <= BIN_W'(cap);
      clipped    = in_cap ? bin_val[LIMIT_W-1:0] : cap;
      idx_ext      = IDX_W'(read_index_ff);
      idx_in_range = idx_ext < IDX_W'(BIN_DEPTH);
   end

   // Memory address and write decision for the command in the bin cycle.
   always_comb begin
      rd_addr  = (cmd_ff == CMD_ADD) ? bin_val[ADDR_W-1:0] : idx_ext[ADDR_W-1:0];
      wr_en_in = ((cmd_ff == CMD_ADD) && in_cap) ||
                 ((cmd_ff == CMD_READ) && idx_in_range);
   end

   // Length tracker update, done in the bin cycle.
   always_comb begin
      largest_in = largest_ff;
      if (state_ff == ST_BIN) begin
         case (cmd_ff)
            CMD_ADD: begin
               if (clipped > largest_ff) begin
                  largest_in = clipped;
               end
            end
            CMD_RESTART: begin
               largest_in = '0;
            end
            default: begin
               largest_in = largest_ff;
            end
         endcase
      end
   end

   // Saturating adds for every band of the fetched entry.
   always_comb begin
      rd_wide = WIDE_W'(rd_data_ff);
      for (int b = 0; b < MAX_BANDS; b++) begin
         add_wide[b*SUM_W +: SUM_W] = sat_add(sum_type'(rd_wide[b*SUM_W +: SUM_W]), vol_ff[b]);
      end
   end

   // Memory write port: the clearing pass or the write-back of a command.
   always_comb begin
      mem_we    = (state_ff == ST_CLEAR) || ((state_ff == ST_MOD) && wr_en_ff);
      mem_waddr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr_ff;
      if ((state_ff == ST_MOD) && (cmd_ff == CMD_ADD)) begin
         mem_wdata = add_wide[WORD_W-1:0];
      end else begin
         mem_wdata = '0;
      end
   end

   // Bin memory with a registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_waddr] <= mem_wdata;
      end
      if (state_ff == ST_BIN) begin
         rd_data_ff <= bin_mem[rd_addr];
      end
   end

   // Control state and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         largest_ff     <= '0;
         sample_rate_ff <= RATE_RESET;
         max_bin_ff     <= MAX_BIN_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         largest_ff   <= largest_in;
         rsp_valid_ff <= (state_ff == ST_MOD) && (cmd_ff == CMD_READ);
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         end
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata[RATE_W-1:0];
               CSR_MAX_BIN:     max_bin_ff     <= csr_wdata[LIMIT_W-1:0];
            endcase
         end
      end
   end

   // Command capture on transfer; the product is formed on the way in.
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff        <= req_cmd;
         prod_ff       <= PROD_W'(req_arrival_time) * PROD_W'(sample_rate_ff);
         read_index_ff <= req_read_index;
         for (int b = 0; b < MAX_BANDS; b++) begin
            vol_ff[b] <= vol_req[b];
         end
      end
      if (state_ff == ST_BIN) begin
         addr_ff     <= rd_addr;
         wr_en_ff    <= wr_en_in;
         in_range_ff <= idx_in_range;
      end
   end

   // Result registers, loaded in the write-back cycle of a read.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_MOD) && (cmd_ff == CMD_READ)) begin
         for (int b = 0; b < MAX_BANDS; b++) begin
            rsp_sum_ff[b] <= in_range_ff ? sum_type'(rd_wide[b*SUM_W +: SUM_W]) : '0;
         end
         rsp_len_ff      <= LEN_W'(largest_ff) + LEN_W'(1);
         rsp_bin_echo_ff <= read_index_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_band_sum_0      = rsp_sum_ff[0];
   assign rsp_band_sum_1      = rsp_sum_ff[1];
   assign rsp_band_sum_2      = rsp_sum_ff[2];
   assign rsp_band_sum_3      = rsp_sum_ff[3];
   assign rsp_band_sum_4      = rsp_sum_ff[4];
   assign rsp_band_sum_5      = rsp_sum_ff[5];
   assign rsp_band_sum_6      = rsp_sum_ff[6];
   assign rsp_band_sum_7      = rsp_sum_ff[7];
   assign rsp_response_length = rsp_len_ff;
   assign rsp_bin_echo        = rsp_bin_echo_ff;

   // A memory read is always followed by its write-back cycle.
   `ITBA_ASSERT_NEXT(a_bin_then_mod, clock, reset, state_ff == ST_BIN, state_ff == ST_MOD)
   // Every read command produces a strobe after write-back.
   `ITBA_ASSERT_NEXT(a_read_responds, clock, reset, state_ff == ST_MOD && cmd_ff == CMD_READ, rsp_valid)
   // A strobe only ever follows a write-back cycle.
   `ITBA_ASSERT_IMPL(a_rsp_after_mod, clock, reset, rsp_valid, $past(state_ff) == ST_MOD)

endmodule

// ----- dv/bin_sum_checker.sv -----
// ----------------------------------------------------------------------------
// Bin sum checker
// Watches the command, result and register ports of the time-bin accumulator,
// keeps its own copy of the bin store and length tracker, works out the
// expected readout for every read and compares each result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bin_sum_checker
   import itba_pkg::*;
#(
   parameter int unsigned BIN_DEPTH = 65536,
   parameter int unsigned BANDS     = 8
)(
   input  logic                              clock,
   input  logic                              reset,
   // Command channel
   input  logic                              start,
   input  logic                              busy,
   input  logic [CMD_W-1:0]                  req_cmd,
   input  logic [TIME_W-1:0]                 req_arrival_time,
   input  logic [MAX_BANDS-1:0][VOL_W-1:0]   req_volumes,
   input  logic [LIMIT_W-1:0]                req_read_index,
   // Result channel
   input  logic                              rsp_valid,
   input  logic [MAX_BANDS-1:0][SUM_W-1:0]   rsp_sums,
   input  logic [LEN_W-1:0]                  rsp_response_length,
   input  logic [LIMIT_W-1:0]                rsp_bin_echo,
   // Register write port
   input  logic                              csr_write_en,
   input  logic [CSR_IDX_W-1:0]              csr_index,
   input  logic [CSR_DATA_W-1:0]             csr_wdata,
   // Status for the testbench top
   output int                                mismatch_count,
   output int                                reads_outstanding
);

   localparam logic [63:0] HALF_BIN = 64'd1 << (ROUND_SHIFT - 1);
   localparam longint SUM_HIGH = 64'sd2147483647;
   localparam longint SUM_LOW  = -64'sd2147483648;

   // What one read is expected to return.
   typedef struct {
      logic [MAX_BANDS-1:0][SUM_W-1:0] sums;
      logic [LEN_W-1:0]                response_length;
      logic [LIMIT_W-1:0]              bin_echo;
   } bin_readout_type;

   bin_readout_type read_results_due [$];

   // Predicted state. The store powers up at zero, as the block's clearing
   // pass leaves it, and reset is applied only once.
   bit signed [SUM_W-1:0] bin_store [BIN_DEPTH][MAX_BANDS];
   logic [RATE_W-1:0]     sample_rate_q;
   logic [LIMIT_W-1:0]    max_bin_q;
   logic [LIMIT_W-1:0]    largest_bin_q;
   int                    mismatches = 0;

   assign mismatch_count = mismatches;

   task automatic report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatches++;
   endtask

   // Adds a volume into a band total and clamps to the 32-bit signed range.
   function automatic logic [SUM_W-1:0] saturate_band(input logic signed [SUM_W-1:0] acc,
                                                     input logic signed [VOL_W-1:0] vol);
      longint total;
      total = longint'(acc) + longint'(vol);
      if (total > SUM_HIGH) begin
         total = SUM_HIGH;
      end else if (total < SUM_LOW) begin
         total = SUM_LOW;
      end
      return SUM_W'(total);
   endfunction

   always @(posedge clock) begin : predict_and_compare
      logic [63:0]     product;
      logic [63:0]     bin_index;
      logic [63:0]     bin_cap;
      logic [63:0]     clipped;
      bin_readout_type due;
      if (reset) begin
         sample_rate_q = RATE_RESET;
         max_bin_q     = MAX_BIN_RESET;
         largest_bin_q = '0;
         read_results_due.delete();
      end else begin
         // Check a result transfer against the oldest read still waiting.
         if (rsp_valid) begin
            if (read_results_due.size() == 0) begin
               report_mismatch($sformatf("result for bin %0d with no read waiting",
                                         rsp_bin_echo));
            end else begin
               due = read_results_due.pop_front();
               if (rsp_bin_echo !== due.bin_echo) begin
                  report_mismatch($sformatf("bin echo %0d, expected %0d",
                                            rsp_bin_echo, due.bin_echo));
               end
               if (rsp_response_length !== due.response_length) begin
                  report_mismatch($sformatf("bin %0d length %0d, expected %0d",
                                            due.bin_echo, rsp_response_length,
                                            due.response_length));
               end
               for (int k = 0; k < MAX_BANDS; k++) begin
                  if (rsp_sums[k] !== due.sums[k]) begin
                     report_mismatch($sformatf("bin %0d band %0d sum %0d, expected %0d",
                                               due.bin_echo, k, $signed(rsp_sums[k]),
                                               $signed(due.sums[k])));
                  end
               end
            end
         end

         // Apply an accepted command to the predicted state.
         if (start && !busy) begin
            case (req_cmd)
               CMD_ADD: begin
                  product   = 64'(req_arrival_time) * 64'(sample_rate_q);
                  bin_index = (product + HALF_BIN) >> ROUND_SHIFT;
                  bin_cap   = (64'(max_bin_q) > 64'(BIN_DEPTH - 1)) ? 64'(BIN_DEPTH - 1)
                                                                   : 64'(max_bin_q);
                  clipped   = (bin_index < bin_cap) ? bin_index : bin_cap;
                  // The length tracker rises even when the impulse is dropped.
                  if (clipped > 64'(largest_bin_q)) begin
                     largest_bin_q = LIMIT_W'(clipped);
                  end
                  if (bin_index <= bin_cap) begin
                     for (int k = 0; k < BANDS; k++) begin
                        bin_store[bin_index][k] = saturate_band(bin_store[bin_index][k],
                                                                req_volumes[k]);
                     end
                  end
               end
               CMD_READ: begin
                  due.sums = '0;
                  if (req_read_index < BIN_DEPTH) begin
                     for (int k = 0; k < BANDS; k++) begin
                        due.sums[k] = bin_store[req_read_index][k];
                        bin_store[req_read_index][k] = '0;
                     end
                  end
                  due.response_length = {1'b0, largest_bin_q} + 1'b1;
                  due.bin_echo        = req_read_index;
                  read_results_due.push_back(due);
               end
               CMD_RESTART: begin
                  largest_bin_q = '0;
               end
               default: begin
                  // The unused code leaves everything as it is.
               end
            endcase
         end

         // Register writes only come while the block is idle.
         if (csr_write_en) begin
            case (csr_index)
               CSR_SAMPLE_RATE: sample_rate_q = csr_wdata[RATE_W-1:0];
               CSR_MAX_BIN:     max_bin_q     = csr_wdata[LIMIT_W-1:0];
               default: begin
               end
            endcase
         end
      end
      reads_outstanding <= read_results_due.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Time-bin accumulator testbench
// Drives directed and random add, read, restart and unused commands through
// several register settings, with bursty command timing, while the bin sum
// checker predicts every readout and counts mismatches. A watchdog ends the
// run if nothing transfers for far longer than the clearing pass takes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top
   import itba_pkg::*;
();

   localparam int unsigned BIN_DEPTH     = 65536;
   localparam int unsigned BANDS         = 8;
   localparam int unsigned IDLE_LIMIT    = 4 * BIN_DEPTH;
   localparam int unsigned SETTLE_CYCLES = 4;

   localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
   localparam logic [VOL_W-1:0]  VOL_MAX    = 24'h7FFFFF;
   localparam logic [VOL_W-1:0]  VOL_MIN    = 24'h800000;
   // 2^-3 s at 44100 samples per second lands exactly on bin 5512.5.
   localparam logic [TIME_W-1:0] HALF_TIME  = 32'h0002_0000;

   typedef logic [MAX_BANDS-1:0][VOL_W-1:0] volume_set_type;

   logic                            clock;
   logic                            reset;
   logic                            start;
   logic                            busy;
   logic [CMD_W-1:0]                req_cmd;
   logic [TIME_W-1:0]               req_arrival_time;
   volume_set_type                  req_volumes;
   logic [LIMIT_W-1:0]              req_read_index;
   logic                            rsp_valid;
   wire  [MAX_BANDS-1:0][SUM_W-1:0] rsp_sums;
   logic [LEN_W-1:0]                rsp_response_length;
   logic [LIMIT_W-1:0]              rsp_bin_echo;
   logic                            csr_write_en;
   logic [CSR_IDX_W-1:0]            csr_index;
   logic [CSR_DATA_W-1:0]           csr_wdata;
   int                              mismatch_count;
   int                              reads_outstanding;
   int unsigned                     burst_left;
   int unsigned                     idle_cycles = 0;
   volume_set_type                  vols;

   impulse_time_bin_accumulator #(
      .BIN_DEPTH (BIN_DEPTH),
      .BANDS     (BANDS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_arrival_time    (req_arrival_time),
      .req_band_volume_0   (req_volumes[0]),
      .req_band_volume_1   (req_volumes[1]),
      .req_band_volume_2   (req_volumes[2]),
      .req_band_volume_3   (req_volumes[3]),
      .req_band_volume_4   (req_volumes[4]),
      .req_band_volume_5   (req_volumes[5]),
      .req_band_volume_6   (req_volumes[6]),
      .req_band_volume_7   (req_volumes[7]),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_band_sum_0      (rsp_sums[0]),
      .rsp_band_sum_1      (rsp_sums[1]),
      .rsp_band_sum_2      (rsp_sums[2]),
      .rsp_band_sum_3      (rsp_sums[3]),
      .rsp_band_sum_4      (rsp_sums[4]),
      .rsp_band_sum_5      (rsp_sums[5]),
      .rsp_band_sum_6      (rsp_sums[6]),
      .rsp_band_sum_7      (rsp_sums[7]),
      .rsp_response_length (rsp_response_length),
      .rsp_bin_echo        (rsp_bin_echo),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   bin_sum_checker #(
      .BIN_DEPTH (BIN_DEPTH),
      .BANDS     (BANDS)
   ) bin_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_cmd             (req_cmd),
      .req_arrival_time    (req_arrival_time),
      .req_volumes         (req_volumes),
      .req_read_index      (req_read_index),
      .rsp_valid           (rsp_valid),
      .rsp_sums            (rsp_sums),
      .rsp_response_length (rsp_response_length),
      .rsp_bin_echo        (rsp_bin_echo),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .reads_outstanding   (reads_outstanding)
   );

   // 20 ns clock.
   always begin : clock_gen
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Ends the run when no transfer of any kind happens for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (start && !busy) || rsp_valid || csr_write_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("tb_top failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic volume_set_type uniform_volumes(input logic [VOL_W-1:0] value);
      volume_set_type set;
      for (int k = 0; k < MAX_BANDS; k++) begin
         set[k] = value;
      end
      return set;
   endfunction

   // Mostly random volumes, with the extremes, zero and minus one mixed in.
   function automatic volume_set_type random_volumes();
      volume_set_type set;
      for (int k = 0; k < MAX_BANDS; k++) begin
         case ($urandom_range(0, 9))
            0:       set[k] = VOL_MAX;
            1:       set[k] = VOL_MIN;
            2:       set[k] = '0;
            3:       set[k] = '1;
            default: set[k] = VOL_W'($urandom);
         endcase
      end
      return set;
   endfunction

   // Large volumes with a fixed sign per band, to drive the totals into clamping.
   function automatic volume_set_type heavy_volumes(input logic [MAX_BANDS-1:0] sign_mask);
      volume_set_type   set;
      logic [VOL_W-1:0] magnitude;
      for (int k = 0; k < MAX_BANDS; k++) begin
         magnitude = VOL_W'($urandom_range(32'h780000, 32'h7FFFFF));
         if ($urandom_range(0, 9) == 0) begin
            set[k] = VOL_W'($urandom);
         end else begin
            set[k] = sign_mask[k] ? -magnitude : magnitude;
         end
      end
      return set;
   endfunction

   // Arrival time that maps to the given bin, or with jitter to it or the next.
   function automatic logic [TIME_W-1:0] time_for_bin(input int unsigned bin,
                                                      input logic [RATE_W-1:0] rate,
                                                      input bit jitter);
      logic [63:0] scaled;
      if (rate == '0) begin
         return $urandom;
      end
      scaled = 64'(bin) << ROUND_SHIFT;
      if (jitter) begin
         scaled = scaled + 64'($urandom_range(0, (1 << ROUND_SHIFT) - 1));
      end
      scaled = scaled / 64'(rate);
      return (scaled > 64'hFFFF_FFFF) ? '1 : TIME_W'(scaled);
   endfunction

   // Presents one command, waits for its transfer, then maybe idles a while.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] arrival,
                               input volume_set_type set, input logic [LIMIT_W-1:0] index);
      start            <= 1'b1;
      req_cmd          <= cmd;
      req_arrival_time <= arrival;
      req_volumes      <= set;
      req_read_index   <= index;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // Holds off commands until every read has returned and the block settles.
   task automatic drain();
      start <= 1'b0;
      do begin
         @(posedge clock);
      end while (reads_outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_registers(input logic [RATE_W-1:0] rate, input logic [LIMIT_W-1:0] limit);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= CSR_SAMPLE_RATE;
      csr_wdata    <= CSR_DATA_W'(rate);
      @(posedge clock);
      csr_index    <= CSR_MAX_BIN;
      csr_wdata    <= CSR_DATA_W'(limit);
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Random mix aimed at a small pool of bins so that reads find real totals.
   task automatic run_phase(input logic [RATE_W-1:0] rate, input logic [LIMIT_W-1:0] limit,
                            input int unsigned pool_base, input int unsigned pool_size,
                            input int unsigned count);
      int unsigned pick;
      int unsigned target;
      set_registers(rate, limit);
      for (int unsigned n = 0; n < count; n++) begin
         pick   = $urandom_range(0, 99);
         target = pool_base + $urandom_range(0, pool_size - 1);
         if (pick < 60) begin
            send_command(CMD_ADD,
                         ($urandom_range(0, 9) == 0) ? $urandom
                                                     : time_for_bin(target, rate, 1'b1),
                         random_volumes(), LIMIT_W'($urandom));
         end else if (pick < 88) begin
            send_command(CMD_READ, $urandom, random_volumes(),
                         ($urandom_range(0, 4) == 0) ? LIMIT_W'($urandom)
                                                     : LIMIT_W'(target));
         end else if (pick < 96) begin
            send_command(CMD_RESTART, $urandom, random_volumes(), LIMIT_W'($urandom));
         end else begin
            send_command(CMD_UNUSED, $urandom, random_volumes(), LIMIT_W'($urandom));
         end
      end
   endtask

   // Piles heavy impulses into one bin until the totals clamp, then reads it.
   task automatic run_saturation_phase(input logic [RATE_W-1:0] rate, input int unsigned hot_bin,
                                       input int unsigned count);
      logic [MAX_BANDS-1:0] sign_mask;
      set_registers(rate, MAX_BIN_RESET);
      sign_mask = MAX_BANDS'($urandom);
      for (int unsigned n = 1; n < count; n++) begin
         if ($urandom_range(0, 49) == 0) begin
            send_command(CMD_READ, $urandom, random_volumes(), LIMIT_W'($urandom));
         end else begin
            send_command(CMD_ADD, time_for_bin(hot_bin, rate, 1'b0), heavy_volumes(sign_mask),
                         LIMIT_W'($urandom));
         end
      end
      send_command(CMD_READ, $urandom, random_volumes(), LIMIT_W'(hot_bin));
   endtask

   initial begin : stimulus
      reset            <= 1'b1;
      start            <= 1'b0;
      req_cmd          <= CMD_ADD;
      req_arrival_time <= '0;
      req_volumes      <= '0;
      req_read_index   <= '0;
      csr_write_en     <= 1'b0;
      csr_index        <= CSR_SAMPLE_RATE;
      csr_wdata        <= '0;
      burst_left        = $urandom_range(1, 40);
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings. The first command waits out
      // the clearing pass.
      send_command(CMD_READ, '0, '0, 16'd0);
      send_command(CMD_ADD, '0, uniform_volumes(VOL_MAX), '0);
      send_command(CMD_ADD, '0, uniform_volumes(VOL_MIN), '0);
      for (int k = 0; k < MAX_BANDS; k++) begin
         vols[k] = k[0] ? VOL_MIN : VOL_MAX;
      end
      // Exactly half a bin rounds up; one step less rounds down.
      send_command(CMD_ADD, HALF_TIME, vols, '0);
      send_command(CMD_ADD, HALF_TIME - 1'b1, uniform_volumes(24'd1), '0);
      send_command(CMD_READ, '0, '0, 16'd5513);
      send_command(CMD_READ, '0, '0, 16'd5512);
      send_command(CMD_READ, '0, '0, 16'd0);
      send_command(CMD_UNUSED, '1, '1, '1);
      send_command(CMD_READ, '0, '0, 16'd5513);
      send_command(CMD_RESTART, '1, '1, '1);
      send_command(CMD_READ, '0, '0, 16'd0);
      // A time far past the limit is dropped but clips the length to the top.
      send_command(CMD_ADD, '1, random_volumes(), '0);
      send_command(CMD_READ, '1, '0, '1);
      send_command(CMD_ADD, time_for_bin(BIN_DEPTH - 1, RATE_RESET, 1'b0),
                   uniform_volumes('1), '0);
      send_command(CMD_READ, '0, '0, '1);
      send_command(CMD_RESTART, '0, '0, '0);
      send_command(CMD_READ, '0, '0, '1);

      // Random part over several register settings, extremes included.
      run_phase(RATE_RESET, MAX_BIN_RESET, $urandom_range(0, BIN_DEPTH - 32), 32, 150);
      run_phase(18'd1, 16'd0, 0, 3, 80);
      run_phase(18'd192000, 16'd300, 280, 40, 120);
      run_phase(18'd0, MAX_BIN_RESET, 0, 1, 60);
      run_phase('1, 16'd1000, 980, 40, 100);
      run_saturation_phase(18'd48000, $urandom_range(0, BIN_DEPTH - 1), 360);
      run_phase(RATE_W'($urandom_range(1, 192000)), LIMIT_W'($urandom),
                $urandom_range(0, BIN_DEPTH - 16), 16, 60);

      drain();
      if (mismatch_count == 0 && reads_outstanding == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
